// ===== rtl/bcomp_pkg.sv =====
// Shared types and constants for the barometric compensation block.
// Depends on nothing; every other file of the block uses it by scoped names.
package bcomp_pkg;

    // Field widths.
    localparam int unsigned CalW = 48;
    localparam int unsigned RawW = 20;
    localparam int unsigned OutW = 32;
    localparam int unsigned IdxW = 8;
    localparam int unsigned DivW = 64;

    // Calibration register indexes.
    localparam logic [IdxW-1:0] RegTempCal   = 8'd0;
    localparam logic [IdxW-1:0] RegPressCalA = 8'd1;
    localparam logic [IdxW-1:0] RegPressCalB = 8'd2;
    localparam logic [IdxW-1:0] RegPressCalC = 8'd3;

    // Compensation constants.
    localparam logic signed [33:0] FineOffset = 34'sd128000;
    localparam logic [20:0]        PressBase  = 21'd1048576;
    localparam logic [63:0]        PressScale = 64'd3125;
    localparam logic signed [31:0] CentiMul   = 32'sd5;
    localparam logic signed [31:0] CentiRound = 32'sd128;
    localparam logic [63:0]        DivBias    = 64'h0000_8000_0000_0000;

    // Values that ride alongside the divider.
    typedef struct packed {
        logic [OutW-1:0] centi;
        logic [OutW-1:0] fine;
        logic            div_zero;
    } t_side;

endpackage

// ===== rtl/bcomp_if.sv =====
// Handshake channels of the barometric compensation block: samples, results
// and calibration writes. Depends on bcomp_pkg for field widths.
interface bcomp_sample_if;
    logic                          valid;
    logic                          ready;
    logic [bcomp_pkg::RawW-1:0]    raw_temperature;
    logic [bcomp_pkg::RawW-1:0]    raw_pressure;
    modport source(output valid, raw_temperature, raw_pressure, input ready);
    modport sink(input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bcomp_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [bcomp_pkg::OutW-1:0] temperature_centi;
    logic signed [bcomp_pkg::OutW-1:0] fine_temperature;
    logic [bcomp_pkg::OutW-1:0]        pressure_q24_8;
    logic                              divisor_zero;
    modport source(output valid, temperature_centi, fine_temperature, pressure_q24_8,
                   divisor_zero, input ready);
    modport sink(input valid, temperature_centi, fine_temperature, pressure_q24_8,
                 divisor_zero, output ready);
endinterface

interface bcomp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bcomp_pkg::IdxW-1:0] index;
    logic [bcomp_pkg::CalW-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/bcomp_div.sv =====
// Pipelined 64-bit signed divider, truncating toward zero, one quotient bit per stage.
// Depends on bcomp_pkg for the side-band struct carried with each word.
module bcomp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [bcomp_pkg::DivW-1:0] i_num,
    input  logic [bcomp_pkg::DivW-1:0] i_den,
    input  bcomp_pkg::t_side           i_side,
    output logic                       o_valid,
    output logic [bcomp_pkg::DivW-1:0] o_quo,
    output bcomp_pkg::t_side           o_side
);
    localparam int unsigned W = bcomp_pkg::DivW;

    logic [W-1:0]     r_rem  [0:W];
    logic [W-1:0]     r_nq   [0:W];
    logic [W-1:0]     r_dv   [0:W];
    logic             r_neg  [0:W];
    logic             r_vld  [0:W];
    bcomp_pkg::t_side r_side [0:W];

    logic             r_out_valid;
    logic [W-1:0]     r_out_quo;
    bcomp_pkg::t_side r_out_side;

    // Entry stage: magnitudes and the sign of the quotient.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= '0;
            r_nq[0]   <= i_num[W-1] ? (W'(0) - i_num) : i_num;
            r_dv[0]   <= i_den[W-1] ? (W'(0) - i_den) : i_den;
            r_neg[0]  <= i_num[W-1] ^ i_den[W-1];
            r_side[0] <= i_side;
        end
    end

    // One restoring step per stage; the dividend shifts out as quotient bits shift in.
    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0] trial;
        logic [W:0] diff;
        assign trial = {r_rem[k], r_nq[k][W-1]};
        assign diff  = trial - {1'b0, r_dv[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= diff[W] ? trial[W-1:0] : diff[W-1:0];
                r_nq[k+1]   <= {r_nq[k][W-2:0], ~diff[W]};
                r_dv[k+1]   <= r_dv[k];
                r_neg[k+1]  <= r_neg[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // Exit stage: restore the sign.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_vld[W];
        end
        if (i_en) begin
            r_out_quo  <= r_neg[W] ? (W'(0) - r_nq[W]) : r_nq[W];
            r_out_side <= r_side[W];
        end
    end

    assign o_valid = r_out_valid;
    assign o_quo   = r_out_quo;
    assign o_side  = r_out_side;

endmodule

// ===== rtl/barometric_compensation.sv =====
// Top level of the barometric compensation block: calibration registers and pipeline.
// Depends on bcomp_pkg, the channel interfaces in bcomp_if and the divider bcomp_div.

// The block accepts one raw temperature and pressure word every cycle and
// returns its compensated result at the end of the pipeline, most of which
// is the divider: 64 steps, one quotient bit per stage. A stall on
// the result channel freezes the whole pipeline and drops input ready until
// the output register is taken. Calibration writes are always accepted and
// are meant to happen only while no word is in flight.
module barometric_compensation (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    bcomp_sample_if.sink           i_sample,
    bcomp_result_if.source         o_result,
    bcomp_cfg_if.sink              i_cfg
);
    // Calibration registers.
    logic [bcomp_pkg::CalW-1:0] r_cal_t, r_cal_a, r_cal_b, r_cal_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t <= '0;
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bcomp_pkg::RegTempCal:   r_cal_t <= i_cfg.data;
                bcomp_pkg::RegPressCalA: r_cal_a <= i_cfg.data;
                bcomp_pkg::RegPressCalB: r_cal_b <= i_cfg.data;
                bcomp_pkg::RegPressCalC: r_cal_c <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end
    assign i_cfg.ready = 1'b1;

    // Calibration words.
    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = r_cal_t[15:0];
    assign t2 = $signed(r_cal_t[31:16]);
    assign t3 = $signed(r_cal_t[47:32]);
    assign p1 = r_cal_a[15:0];
    assign p2 = $signed(r_cal_a[31:16]);
    assign p3 = $signed(r_cal_a[47:32]);
    assign p4 = $signed(r_cal_b[15:0]);
    assign p5 = $signed(r_cal_b[31:16]);
    assign p6 = $signed(r_cal_b[47:32]);
    assign p7 = $signed(r_cal_c[15:0]);
    assign p8 = $signed(r_cal_c[31:16]);
    assign p9 = $signed(r_cal_c[47:32]);

    // Global advance: the pipeline moves whenever the output register can load.
    logic en;
    logic r_out_valid;
    assign en             = !r_out_valid || o_result.ready;
    assign i_sample.ready = en;

    // Stage 1: temperature products.
    logic signed [17:0] s1_dt;
    logic signed [16:0] s1_d;
    logic signed [31:0] n1_pa, n1_dd;
    logic               r1_valid;
    logic signed [31:0] r1_pa, r1_dd;
    logic [bcomp_pkg::RawW-1:0] r1_raw_p;
    assign s1_dt = $signed({1'b0, i_sample.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign s1_d  = $signed({1'b0, i_sample.raw_temperature[19:4]}) - $signed({1'b0, t1});
    assign n1_pa = 32'(s1_dt) * 32'(t2);
    assign n1_dd = 32'(s1_d) * 32'(s1_d);

    // Stage 2: scale and apply T3.
    logic signed [31:0] s2_ddsh, n2_b1;
    logic               r2_valid;
    logic signed [31:0] r2_a, r2_b1;
    logic [bcomp_pkg::RawW-1:0] r2_raw_p;
    assign s2_ddsh = r1_dd >>> 12;
    assign n2_b1   = s2_ddsh * 32'(t3);

    // Stage 3: fine temperature.
    logic               r3_valid;
    logic signed [31:0] r3_fine;
    logic [bcomp_pkg::RawW-1:0] r3_raw_p;

    // Stage 4: centi degrees and the pressure offset term.
    logic signed [31:0] n4_c5;
    logic               r4_valid;
    logic signed [31:0] r4_centi, r4_fine;
    logic signed [33:0] r4_v1;
    logic [bcomp_pkg::RawW-1:0] r4_raw_p;
    assign n4_c5 = r3_fine * bcomp_pkg::CentiMul + bcomp_pkg::CentiRound;

    // Stage 5: square and linear products of the offset.
    logic signed [63:0] n5_vv, n5_v1p5, n5_v1p2;
    logic               r5_valid;
    logic signed [63:0] r5_vv, r5_v1p5, r5_v1p2;
    logic signed [31:0] r5_centi, r5_fine;
    logic [bcomp_pkg::RawW-1:0] r5_raw_p;
    assign n5_vv   = 64'(r4_v1) * 64'(r4_v1);
    assign n5_v1p5 = 64'(r4_v1) * 64'(p5);
    assign n5_v1p2 = 64'(r4_v1) * 64'(p2);

    // Stage 6: quadratic terms.
    logic signed [63:0] n6_v2a, n6_t3a;
    logic               r6_valid;
    logic signed [63:0] r6_v2a, r6_t3a, r6_v1p5, r6_v1p2;
    logic signed [31:0] r6_centi, r6_fine;
    logic [bcomp_pkg::RawW-1:0] r6_raw_p;
    assign n6_v2a = r5_vv * 64'(p6);
    assign n6_t3a = r5_vv * 64'(p3);

    // Stage 7: sums for the numerator offset and the divisor.
    logic signed [63:0] s7_p4, n7_v2, n7_x;
    logic               r7_valid;
    logic signed [63:0] r7_v2, r7_x;
    logic signed [31:0] r7_centi, r7_fine;
    logic [bcomp_pkg::RawW-1:0] r7_raw_p;
    assign s7_p4 = 64'(p4);
    assign n7_v2 = r6_v2a + (r6_v1p5 <<< 17) + (s7_p4 <<< 35);
    assign n7_x  = (r6_t3a >>> 8) + (r6_v1p2 <<< 12);

    // Stage 8: divisor product and numerator base.
    logic [20:0]  s8_base;
    logic [63:0]  n8_y, n8_pn;
    logic         r8_valid;
    logic [63:0]  r8_y, r8_pn;
    logic signed [31:0] r8_centi, r8_fine;
    assign s8_base = bcomp_pkg::PressBase - {1'b0, r7_raw_p};
    assign n8_y    = (bcomp_pkg::DivBias + r7_x) * {48'b0, p1};
    assign n8_pn   = ({43'b0, s8_base} << 31) - r7_v2;

    // Stage 9: divisor and scaled numerator.
    logic [63:0]       n9_den, n9_num;
    logic              r9_valid;
    logic [63:0]       r9_den, r9_num;
    bcomp_pkg::t_side  r9_side;
    assign n9_den = $signed(r8_y) >>> 33;
    assign n9_num = r8_pn * bcomp_pkg::PressScale;

    // Divider.
    logic             dv_valid;
    logic [63:0]      dv_quo;
    bcomp_pkg::t_side dv_side;

    bcomp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r9_valid),
        .i_num   (r9_num),
        .i_den   (r9_den),
        .i_side  (r9_side),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // Stage A: partial products of h squared, and the P8 term.
    logic signed [63:0] sa_h;
    logic [63:0]        na_ll;
    logic [31:0]        na_lh;
    logic signed [63:0] na_w2p;
    logic               ra_valid;
    logic [63:0]        ra_ll, ra_q;
    logic [31:0]        ra_lh;
    logic signed [63:0] ra_w2p;
    bcomp_pkg::t_side   ra_side;
    assign sa_h   = $signed(dv_quo) >>> 13;
    assign na_ll  = 64'(sa_h[31:0]) * 64'(sa_h[31:0]);
    assign na_lh  = sa_h[31:0] * sa_h[63:32];
    assign na_w2p = $signed(dv_quo) * 64'(p8);

    // Stage B: h squared and the scaled P8 term.
    logic [63:0]        rb_hsq, rb_q;
    logic signed [63:0] rb_w2;
    logic               rb_valid;
    bcomp_pkg::t_side   rb_side;

    // Stage C: the P9 term.
    logic signed [63:0] nc_w1p;
    logic signed [63:0] rc_w1p, rc_w2;
    logic [63:0]        rc_q;
    logic               rc_valid;
    bcomp_pkg::t_side   rc_side;
    assign nc_w1p = $signed(rb_hsq) * 64'(p9);

    // Output stage: final pressure.
    logic signed [63:0] so_sum, so_res;
    assign so_sum = $signed(rc_q) + (rc_w1p >>> 25) + rc_w2;
    assign so_res = (so_sum >>> 8) + (64'(p7) <<< 4);

    logic signed [31:0] r_out_centi, r_out_fine;
    logic [31:0]        r_out_press;
    logic               r_out_dz;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r7_valid    <= 1'b0;
            r8_valid    <= 1'b0;
            r9_valid    <= 1'b0;
            ra_valid    <= 1'b0;
            rb_valid    <= 1'b0;
            rc_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_sample.valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r6_valid    <= r5_valid;
            r7_valid    <= r6_valid;
            r8_valid    <= r7_valid;
            r9_valid    <= r8_valid;
            ra_valid    <= dv_valid;
            rb_valid    <= ra_valid;
            rc_valid    <= rb_valid;
            r_out_valid <= rc_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pa    <= n1_pa;
            r1_dd    <= n1_dd;
            r1_raw_p <= i_sample.raw_pressure;

            r2_a     <= r1_pa >>> 11;
            r2_b1    <= n2_b1;
            r2_raw_p <= r1_raw_p;

            r3_fine  <= r2_a + (r2_b1 >>> 14);
            r3_raw_p <= r2_raw_p;

            r4_centi <= n4_c5 >>> 8;
            r4_fine  <= r3_fine;
            r4_v1    <= 34'(r3_fine) - bcomp_pkg::FineOffset;
            r4_raw_p <= r3_raw_p;

            r5_vv    <= n5_vv;
            r5_v1p5  <= n5_v1p5;
            r5_v1p2  <= n5_v1p2;
            r5_centi <= r4_centi;
            r5_fine  <= r4_fine;
            r5_raw_p <= r4_raw_p;

            r6_v2a   <= n6_v2a;
            r6_t3a   <= n6_t3a;
            r6_v1p5  <= r5_v1p5;
            r6_v1p2  <= r5_v1p2;
            r6_centi <= r5_centi;
            r6_fine  <= r5_fine;
            r6_raw_p <= r5_raw_p;

            r7_v2    <= n7_v2;
            r7_x     <= n7_x;
            r7_centi <= r6_centi;
            r7_fine  <= r6_fine;
            r7_raw_p <= r6_raw_p;

            r8_y     <= n8_y;
            r8_pn    <= n8_pn;
            r8_centi <= r7_centi;
            r8_fine  <= r7_fine;

            r9_den           <= n9_den;
            r9_num           <= n9_num;
            r9_side.centi    <= r8_centi;
            r9_side.fine     <= r8_fine;
            r9_side.div_zero <= (n9_den == 64'd0);

            ra_ll   <= na_ll;
            ra_lh   <= na_lh;
            ra_w2p  <= na_w2p;
            ra_q    <= dv_quo;
            ra_side <= dv_side;

            rb_hsq  <= ra_ll + {ra_lh[30:0], 1'b0, 32'b0};
            rb_w2   <= ra_w2p >>> 19;
            rb_q    <= ra_q;
            rb_side <= ra_side;

            rc_w1p  <= nc_w1p;
            rc_w2   <= rb_w2;
            rc_q    <= rb_q;
            rc_side <= rb_side;

            r_out_centi <= rc_side.centi;
            r_out_fine  <= rc_side.fine;
            r_out_press <= rc_side.div_zero ? 32'd0 : so_res[31:0];
            r_out_dz    <= rc_side.div_zero;
        end
    end

    // Result word.
    assign o_result.valid             = r_out_valid;
    assign o_result.temperature_centi = r_out_centi;
    assign o_result.fine_temperature  = r_out_fine;
    assign o_result.pressure_q24_8    = r_out_press;
    assign o_result.divisor_zero      = r_out_dz;

endmodule

// ===== test/bcomp_tb_if.sv =====
// Note: the channel interfaces are declared in rtl/bcomp_if.sv and are reused here as they are.
// This file holds the result record that the checker and the testbench top share.
// Depends on bcomp_pkg for field widths.
package bcomp_tb_pkg;

    // One compensated result word as the checker predicts it.
    typedef struct packed {
        logic [bcomp_pkg::OutW-1:0] centi;
        logic [bcomp_pkg::OutW-1:0] fine;
        logic [bcomp_pkg::OutW-1:0] press;
        logic                       div_zero;
    } t_comp_result;

endpackage

// ===== test/bcomp_checker.sv =====
// Checker for the barometric compensation block: it watches the sample, result and
// calibration channels, predicts each result and compares it field by field.
// Depends on bcomp_pkg, bcomp_tb_pkg and the channel interfaces.
module bcomp_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bcomp_sample_if        smp,
    bcomp_result_if        res,
    bcomp_cfg_if           cfg,
    output int             o_errors,
    output int             o_pending
);
    import bcomp_pkg::*;
    import bcomp_tb_pkg::*;

    logic [CalW-1:0] temp_cal, cal_a, cal_b, cal_c;
    t_comp_result    expected_q[$];

    assign o_pending = expected_q.size();

    // Signed 16-bit word of a calibration register.
    function automatic logic signed [63:0] cal_word(logic [CalW-1:0] r, int pos);
        return 64'(signed'(r[pos +: 16]));
    endfunction

    // Integer compensation of one raw sample pair.
    function automatic t_comp_result compensate(logic [RawW-1:0] adc_t, logic [RawW-1:0] adc_p);
        t_comp_result r;
        logic signed [31:0] t1, t2, t3, a, d, b, fine;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] v1, v2, p, h, w1, w2;
        logic [63:0] num, den, q;
        t1 = {16'd0, temp_cal[15:0]};
        t2 = 32'(signed'(temp_cal[31:16]));
        t3 = 32'(signed'(temp_cal[47:32]));
        p1 = {48'd0, cal_a[15:0]};
        p2 = cal_word(cal_a, 16);  p3 = cal_word(cal_a, 32);
        p4 = cal_word(cal_b, 0);   p5 = cal_word(cal_b, 16);  p6 = cal_word(cal_b, 32);
        p7 = cal_word(cal_c, 0);   p8 = cal_word(cal_c, 16);  p9 = cal_word(cal_c, 32);
        // Temperature path, wrapping at 32 bits; the shifts are arithmetic.
        a = signed'(32'(((32'(adc_t >> 3) - (t1 << 1)) * t2))) >>> 11;
        d = 32'(adc_t >> 4) - t1;
        b = 32'(32'((32'(d * d) >>> 12) * t3)) >>> 14;
        fine = a + b;
        r.fine = fine;
        r.centi = 32'(fine * 32'sd5 + 32'sd128) >>> 8;
        // Pressure path, wrapping at 64 bits.
        v1 = 64'(fine) - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = ((64'sh0000_8000_0000_0000 + v1) * p1) >>> 33;
        r.press = '0;
        r.div_zero = (v1 == 0);
        if (v1 != 0) begin
            p = 64'sd1048576 - 64'(adc_p);
            p = ((p <<< 31) - v2) * 64'sd3125;
            // Truncating division on magnitudes; the most negative quotient wraps.
            num = p[63] ? -p : p;
            den = v1[63] ? -v1 : v1;
            q = num / den;
            p = (p[63] != v1[63]) ? -q : q;
            h = p >>> 13;
            w1 = (p9 * h * h) >>> 25;
            w2 = (p8 * p) >>> 19;
            p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
            r.press = p[31:0];
        end
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    initial o_errors = 0;

    // Track calibration, predict on accepted samples and check accepted results.
    always @(posedge i_clk) begin
        t_comp_result want;
        if (!i_rst_n) begin
            temp_cal <= '0; cal_a <= '0; cal_b <= '0; cal_c <= '0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    RegTempCal:   temp_cal <= cfg.data;
                    RegPressCalA: cal_a <= cfg.data;
                    RegPressCalB: cal_b <= cfg.data;
                    RegPressCalC: cal_c <= cfg.data;
                    default: ;
                endcase
            end
            if (smp.valid && smp.ready)
                expected_q.push_back(compensate(smp.raw_temperature, smp.raw_pressure));
            if (res.valid && res.ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected word", res.pressure_q24_8, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (res.temperature_centi !== want.centi)
                        report("temperature_centi", res.temperature_centi, want.centi);
                    if (res.fine_temperature !== want.fine)
                        report("fine_temperature", res.fine_temperature, want.fine);
                    if (res.pressure_q24_8 !== want.press)
                        report("pressure_q24_8", res.pressure_q24_8, want.press);
                    if (res.divisor_zero !== want.div_zero)
                        report("divisor_zero", 32'(res.divisor_zero), 32'(want.div_zero));
                end
            end
        end
    end
endmodule

// ===== test/tb.sv =====
// Testbench top for the barometric compensation block: drives samples and calibration
// writes with random idling and stalls; the checker predicts and compares.
// Depends on bcomp_pkg, the channel interfaces, bcomp_checker and the block.
module tb;
    import bcomp_pkg::*;

    localparam int Latency = 79;
    localparam int WatchLimit = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending;
    int   send_idle = 0, recv_idle = 0;
    bit   hold_off = 0;
    int   quiet = 0;

    bcomp_sample_if smp();
    bcomp_result_if res();
    bcomp_cfg_if    cfg();

    barometric_compensation u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sample(smp), .o_result(res), .i_cfg(cfg)
    );

    bcomp_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .smp(smp), .res(res), .cfg(cfg),
        .o_errors(errors), .o_pending(pending)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        smp.valid = 0; smp.raw_temperature = '0; smp.raw_pressure = '0;
        cfg.valid = 0; cfg.index = '0; cfg.data = '0;
        res.ready = 0;
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(negedge i_clk)
        res.ready <= !hold_off && ($urandom_range(99) >= recv_idle);

    // Watchdog on cycles where no word moves on any channel.
    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WatchLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_cal(logic [IdxW-1:0] idx, logic [CalW-1:0] value);
        @(negedge i_clk);
        cfg.valid <= 1; cfg.index <= idx; cfg.data <= value;
        do @(posedge i_clk); while (!cfg.ready);
        @(negedge i_clk);
        cfg.valid <= 0;
    endtask

    // Offer one sample pair, idling first at the sender's rate.
    task automatic send_sample(logic [RawW-1:0] t, logic [RawW-1:0] p);
        while ($urandom_range(99) < send_idle) begin
            smp.valid <= 0;
            @(negedge i_clk);
        end
        smp.valid <= 1; smp.raw_temperature <= t; smp.raw_pressure <= p;
        do @(posedge i_clk); while (!smp.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        smp.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (Latency + 5) @(negedge i_clk);
    endtask

    // Random calibration words; P1 must be nonzero for a useful divisor.
    function automatic logic [CalW-1:0] rand_cal();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    task automatic set_typical();
        write_cal(RegTempCal,   {16'sd50, 16'sd26435, 16'd27504});
        write_cal(RegPressCalA, {16'sd3024, -16'sd10685, 16'd36477});
        write_cal(RegPressCalB, {-16'sd7, 16'sd140, 16'sd2855});
        write_cal(RegPressCalC, {16'sd6000, -16'sd14600, 16'sd15500});
    endtask

    task automatic random_phase(int count);
        logic [RawW-1:0] t, p;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) != 0) begin
                t = 20'($urandom_range(380000, 620000));
                p = 20'($urandom_range(200000, 700000));
            end else begin
                t = 20'($urandom); p = 20'($urandom);
            end
            send_sample(t, p);
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Reset calibration: every divisor is zero.
        send_sample('0, '0);
        send_sample('1, '1);
        drain();

        // Directed: field extremes and an unknown register index that is ignored.
        set_typical();
        write_cal(8'd7, '1);
        send_sample('0, '0);
        send_sample('1, '1);
        send_sample('0, '1);
        send_sample('1, '0);
        send_sample(20'd519888, 20'd415148);
        send_sample(20'h55555, 20'hAAAAA);
        send_sample(20'hAAAAA, 20'h55555);
        drain();

        // Extreme calibration words, all ones and the most negative values.
        write_cal(RegTempCal, '1);
        write_cal(RegPressCalA, '1);
        write_cal(RegPressCalB, '1);
        write_cal(RegPressCalC, '1);
        send_sample('1, '1);
        send_sample('0, '0);
        send_sample(20'h80000, 20'h7FFFF);
        drain();
        write_cal(RegPressCalA, {16'h8000, 16'h8000, 16'hFFFF});
        write_cal(RegTempCal, {16'h8000, 16'h8000, 16'hFFFF});
        write_cal(RegPressCalB, {16'h8000, 16'h7FFF, 16'h8000});
        write_cal(RegPressCalC, {16'h7FFF, 16'h8000, 16'h7FFF});
        send_sample('1, '0);
        send_sample(20'h12345, 20'hFEDCB);
        drain();

        // Random phases: sender idles 19%, receiver 54%, then swapped, then none.
        set_typical();
        send_idle = 19; recv_idle = 54;
        random_phase(300);
        drain();
        write_cal(RegTempCal, rand_cal());
        write_cal(RegPressCalA, rand_cal());
        write_cal(RegPressCalB, rand_cal());
        write_cal(RegPressCalC, rand_cal());
        random_phase(150);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        set_typical();
        send_idle = 0;
        hold_off = 1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            random_phase(200);
        join
        drain();

        send_idle = 54; recv_idle = 19;
        random_phase(350);
        drain();
        send_idle = 0; recv_idle = 0;
        random_phase(400);
        drain();

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/bcomp_pkg.sv
rtl/bcomp_if.sv
rtl/bcomp_div.sv
rtl/barometric_compensation.sv
test/bcomp_tb_if.sv
test/bcomp_checker.sv
test/tb.sv
